### src/abi_pkg.sv
// Shared types and constants for the automation breakpoint interpolator.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package abi_pkg;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_NONE = 2'd2;

  localparam logic [2:0] SHAPE_SQUARE  = 3'd1;
  localparam logic [2:0] SHAPE_SQRT    = 3'd2;
  localparam logic [2:0] SHAPE_BEZIER  = 3'd3;
  localparam logic [2:0] SHAPE_SINE    = 3'd4;
  localparam logic [2:0] SHAPE_STEPPED = 3'd5;

  localparam logic [1:0] CFG_DEFAULT_LEVEL = 2'd0;
  localparam logic [1:0] CFG_MATCH_TOL     = 2'd1;

  localparam logic [4:0] DIV_STEPS  = 5'd16;
  localparam logic [4:0] SQRT_STEPS = 5'd16;

  localparam longint PI_HALF_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;

  typedef enum logic [5:0] {
    ST_IDLE, ST_CLEAR, ST_ASCAN, ST_WR_UPD, ST_FULL, ST_SH_INIT, ST_SH_RD, ST_SH_CMP,
    ST_WR_NEW, ST_RSCAN, ST_RM_RD, ST_RM_WR, ST_RM_DONE, ST_NOMATCH, ST_QSCAN, ST_QSEL,
    ST_DIV, ST_SHAPE, ST_SQR, ST_SQRT, ST_BZ_UU, ST_BZ_A, ST_BZ_TT, ST_BZ_B, ST_BZ_TTT,
    ST_BZ_PA, ST_BZ_PB, ST_BZ_SUM, ST_SIN_IDX, ST_SIN_VAL, ST_LERP, ST_FIN, ST_RESP
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CLEAR, OP_SCAN, OP_WR_UPD, OP_FULL, OP_SH_INIT, OP_SH_RD,
    OP_SH_CMP, OP_WR_NEW, OP_RM_RD, OP_RM_WR, OP_RM_DONE, OP_NOMATCH, OP_QSEL, OP_DIV,
    OP_SHAPE, OP_SQR, OP_SQRT, OP_BZ_UU, OP_BZ_A, OP_BZ_TT, OP_BZ_B, OP_BZ_TTT,
    OP_BZ_PA, OP_BZ_PB, OP_BZ_SUM, OP_SIN_IDX, OP_SIN_VAL, OP_LERP, OP_FIN
  } dp_op_t;

  typedef struct packed {
    logic       hit;
    logic       scan_end;
    logic       full;
    logic       p_zero;
    logic       sh_move;
    logic       rm_end;
    logic       direct;
    logic       cnt_last;
    logic [2:0] shape;
  } dp_status_t;

  typedef struct packed {
    logic [31:0]        tm;
    logic [15:0]        lvl;
    logic [2:0]         shape;
    logic signed [15:0] c1;
    logic signed [15:0] c2;
  } point_t;

endpackage

`default_nettype wire

### src/automation_breakpoint_interpolator.sv
// Top level of the automation breakpoint interpolator.
// Depends on abi_pkg, abi_ctrl and abi_dp.
//
// One item at a time: start is taken while busy is low, and the result appears
// on status, level_out and point_count for the single cycle in which done is high;
// the receiver cannot stall it. Every item but a clear first scans the stored points
// through the single read port of the point memory, one point a cycle. A query
// that falls between two points then runs a serial divide, any shaping step of
// its curve (squaring, serial square root, Bezier steps or sine table) and the
// interpolation. An add that inserts moves each later point up one place, reading
// and then writing it, as does a remove for each later point that it moves down.
// Configuration writes are always ready and take effect at once.
`default_nettype none

module automation_breakpoint_interpolator #(
  parameter int MAX_POINTS      = 64,
  parameter int SINE_TABLE_SIZE = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  output logic                    done,
  input  wire logic [1:0]         mode,
  input  wire logic [31:0]        time_stamp,
  input  wire logic [15:0]        level_in,
  input  wire logic [2:0]         curve_shape,
  input  wire logic signed [15:0] ctrl_one,
  input  wire logic signed [15:0] ctrl_two,
  output logic [1:0]              status,
  output logic [15:0]             level_out,
  output logic [6:0]              point_count,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import abi_pkg::*;

  dp_op_t     op;
  dp_status_t st;

  assign cfg_ready = 1'b1;

  abi_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .st    (st),
    .op    (op),
    .busy  (busy),
    .done  (done)
  );

  abi_dp #(
    .MAX_POINTS      (MAX_POINTS),
    .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .st          (st),
    .time_stamp  (time_stamp),
    .level_in    (level_in),
    .curve_shape (curve_shape),
    .ctrl_one    (ctrl_one),
    .ctrl_two    (ctrl_two),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .status      (status),
    .level_out   (level_out),
    .point_count (point_count)
  );

endmodule

`default_nettype wire

### src/abi_ctrl.sv
// Sequencing state machine for the breakpoint interpolator.
// Depends on abi_pkg; drives datapath operations from datapath status.
`default_nettype none

module abi_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [1:0]          mode,
  input  abi_pkg::dp_status_t      st,
  output abi_pkg::dp_op_t          op,
  output logic                     busy,
  output logic                     done
);
  import abi_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (mode)
            MODE_ADD:    state_next = ST_ASCAN;
            MODE_REMOVE: state_next = ST_RSCAN;
            MODE_QUERY:  state_next = ST_QSCAN;
            default:     state_next = ST_CLEAR;
          endcase
        end
      end
      ST_CLEAR:   state_next = ST_RESP;
      ST_ASCAN: begin
        if (st.hit) begin
          state_next = ST_WR_UPD;
        end else if (st.scan_end) begin
          state_next = st.full ? ST_FULL : ST_SH_INIT;
        end
      end
      ST_WR_UPD:  state_next = ST_RESP;
      ST_FULL:    state_next = ST_RESP;
      ST_SH_INIT: state_next = ST_SH_RD;
      ST_SH_RD:   state_next = st.p_zero ? ST_WR_NEW : ST_SH_CMP;
      ST_SH_CMP:  state_next = st.sh_move ? ST_SH_RD : ST_WR_NEW;
      ST_WR_NEW:  state_next = ST_RESP;
      ST_RSCAN: begin
        if (st.hit) begin
          state_next = ST_RM_RD;
        end else if (st.scan_end) begin
          state_next = ST_NOMATCH;
        end
      end
      ST_RM_RD:   state_next = st.rm_end ? ST_RM_DONE : ST_RM_WR;
      ST_RM_WR:   state_next = ST_RM_RD;
      ST_RM_DONE: state_next = ST_RESP;
      ST_NOMATCH: state_next = ST_RESP;
      ST_QSCAN: begin
        if (st.scan_end) begin
          state_next = ST_QSEL;
        end
      end
      ST_QSEL:    state_next = st.direct ? ST_RESP : ST_DIV;
      ST_DIV: begin
        if (st.cnt_last) begin
          state_next = ST_SHAPE;
        end
      end
      ST_SHAPE: begin
        case (st.shape)
          SHAPE_SQUARE: state_next = ST_SQR;
          SHAPE_SQRT:   state_next = ST_SQRT;
          SHAPE_BEZIER: state_next = ST_BZ_UU;
          SHAPE_SINE:   state_next = ST_SIN_IDX;
          default:      state_next = ST_LERP;
        endcase
      end
      ST_SQR:     state_next = ST_LERP;
      ST_SQRT: begin
        if (st.cnt_last) begin
          state_next = ST_LERP;
        end
      end
      ST_BZ_UU:   state_next = ST_BZ_A;
      ST_BZ_A:    state_next = ST_BZ_TT;
      ST_BZ_TT:   state_next = ST_BZ_B;
      ST_BZ_B:    state_next = ST_BZ_TTT;
      ST_BZ_TTT:  state_next = ST_BZ_PA;
      ST_BZ_PA:   state_next = ST_BZ_PB;
      ST_BZ_PB:   state_next = ST_BZ_SUM;
      ST_BZ_SUM:  state_next = ST_LERP;
      ST_SIN_IDX: state_next = ST_SIN_VAL;
      ST_SIN_VAL: state_next = ST_LERP;
      ST_LERP:    state_next = ST_FIN;
      ST_FIN:     state_next = ST_RESP;
      ST_RESP:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    op   = OP_NONE;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        op   = start ? OP_LOAD : OP_NONE;
      end
      ST_CLEAR:   op = OP_CLEAR;
      ST_ASCAN:   op = OP_SCAN;
      ST_WR_UPD:  op = OP_WR_UPD;
      ST_FULL:    op = OP_FULL;
      ST_SH_INIT: op = OP_SH_INIT;
      ST_SH_RD:   op = OP_SH_RD;
      ST_SH_CMP:  op = OP_SH_CMP;
      ST_WR_NEW:  op = OP_WR_NEW;
      ST_RSCAN:   op = OP_SCAN;
      ST_RM_RD:   op = OP_RM_RD;
      ST_RM_WR:   op = OP_RM_WR;
      ST_RM_DONE: op = OP_RM_DONE;
      ST_NOMATCH: op = OP_NOMATCH;
      ST_QSCAN:   op = OP_SCAN;
      ST_QSEL:    op = OP_QSEL;
      ST_DIV:     op = OP_DIV;
      ST_SHAPE:   op = OP_SHAPE;
      ST_SQR:     op = OP_SQR;
      ST_SQRT:    op = OP_SQRT;
      ST_BZ_UU:   op = OP_BZ_UU;
      ST_BZ_A:    op = OP_BZ_A;
      ST_BZ_TT:   op = OP_BZ_TT;
      ST_BZ_B:    op = OP_BZ_B;
      ST_BZ_TTT:  op = OP_BZ_TTT;
      ST_BZ_PA:   op = OP_BZ_PA;
      ST_BZ_PB:   op = OP_BZ_PB;
      ST_BZ_SUM:  op = OP_BZ_SUM;
      ST_SIN_IDX: op = OP_SIN_IDX;
      ST_SIN_VAL: op = OP_SIN_VAL;
      ST_LERP:    op = OP_LERP;
      ST_FIN:     op = OP_FIN;
      ST_RESP:    done = 1'b1;
      default:    op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

### src/abi_dp.sv
// Datapath of the breakpoint interpolator: point memory, scan, divider,
// square root, shared multiplier and sine table. Depends on abi_pkg.
`default_nettype none

module abi_dp #(
  parameter int MAX_POINTS      = 64,
  parameter int SINE_TABLE_SIZE = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  abi_pkg::dp_op_t         op,
  output abi_pkg::dp_status_t     st,
  input  wire logic [31:0]        time_stamp,
  input  wire logic [15:0]        level_in,
  input  wire logic [2:0]         curve_shape,
  input  wire logic signed [15:0] ctrl_one,
  input  wire logic signed [15:0] ctrl_two,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  output logic [1:0]              status,
  output logic [15:0]             level_out,
  output logic [6:0]              point_count
);
  import abi_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int SW = $clog2(SINE_TABLE_SIZE + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);
  localparam logic [SW+1:0] SIN_TOP = (SW + 2)'(SINE_TABLE_SIZE);

  typedef logic [16:0] rom_t [SINE_TABLE_SIZE + 1];

  function automatic logic [16:0] sine_q16(input longint x);
    longint x2;
    longint r;
    longint s;
    x2 = (x * x) >>> 30;
    r  = ONE_Q30;
    r  = ONE_Q30 - ((x2 * r) >>> 30) / 110;
    r  = ONE_Q30 - ((x2 * r) >>> 30) / 72;
    r  = ONE_Q30 - ((x2 * r) >>> 30) / 42;
    r  = ONE_Q30 - ((x2 * r) >>> 30) / 20;
    r  = ONE_Q30 - ((x2 * r) >>> 30) / 6;
    s  = (x * r) >>> 30;
    s  = (s + 64'sd8192) >>> 14;
    if (s > 64'sd65536) begin
      s = 64'sd65536;
    end
    return 17'(s);
  endfunction

  function automatic rom_t build_rom();
    rom_t rom;
    for (int k = 0; k <= SINE_TABLE_SIZE; k++) begin
      rom[k] = sine_q16((PI_HALF_Q30 * longint'(k)) / SINE_TABLE_SIZE);
    end
    return rom;
  endfunction

  function automatic logic signed [15:0] sat_ctrl(input logic signed [15:0] v);
    if (v > 16'sd16384) begin
      return 16'sd16384;
    end else if (v < -16'sd16384) begin
      return -16'sd16384;
    end
    return v;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // configuration and item registers
  logic [15:0]        default_level;
  logic [15:0]        match_tol;
  logic [31:0]        q;
  point_t             new_pt;
  logic [CW-1:0]      count;

  // point memory
  point_t             mem [MAX_POINTS];
  point_t             rdata;
  point_t             wdata;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic               we;

  // scan
  logic [CW-1:0]      ptr;
  logic               rd_vld;
  logic [AW-1:0]      rd_idx;
  logic [AW-1:0]      p;
  logic [31:0]        mtime;
  logic               bf;
  logic               af;
  point_t             b_pt;
  logic [31:0]        a_tm;
  logic [15:0]        a_lvl;

  // arithmetic
  logic [31:0]        rem;
  logic [31:0]        den;
  logic [4:0]         cnt;
  logic [15:0]        t;
  logic [16:0]        u;
  logic [16:0]        uu;
  logic [16:0]        bza;
  logic [16:0]        tt;
  logic [16:0]        bzb;
  logic [16:0]        ttt;
  logic signed [22:0] c;
  logic signed [40:0] acc;
  logic [31:0]        sv;
  logic [31:0]        sres;
  logic [31:0]        sbit;
  logic [16:0]        s_val;
  logic [1:0]         res_status;
  logic [15:0]        res_level;

  logic [31:0]        tdist;
  logic [32:0]        r2;
  logic [32:0]        rsub;
  logic               ge;
  logic [31:0]        rb;
  logic               sge;
  logic [31:0]        sres_next;
  logic signed [17:0] ma;
  logic signed [22:0] mb;
  logic signed [40:0] mp;
  logic signed [16:0] diff;
  logic signed [16:0] c2s;
  logic signed [40:0] bz_sum;
  logic signed [40:0] acc_rnd;
  logic signed [25:0] lvl_sum;
  logic [16:0]        w;
  logic [SW+17:0]     sprod;
  logic [SW+1:0]      sidx_full;
  logic [SW-1:0]      sidx;
  logic [17:0]        sin_hi;
  logic [17:0]        sin_lo;
  logic [15:0]        lvl_sat;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    raddr = ptr[AW-1:0];
    case (op)
      OP_SH_RD: raddr = p - AW'(1);
      OP_RM_RD: raddr = p + AW'(1);
      default:  raddr = ptr[AW-1:0];
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = p;
    wdata = new_pt;
    case (op)
      OP_WR_UPD: begin
        we       = 1'b1;
        wdata.tm = mtime;
      end
      OP_SH_CMP: begin
        we    = st.sh_move;
        wdata = rdata;
      end
      OP_WR_NEW: we = 1'b1;
      OP_RM_WR: begin
        we    = 1'b1;
        wdata = rdata;
      end
      default: we = 1'b0;
    endcase
  end

  always_comb begin
    tdist       = (rdata.tm > q) ? rdata.tm - q : q - rdata.tm;
    st.hit      = rd_vld && (tdist <= {16'b0, match_tol});
    st.scan_end = !rd_vld && (ptr >= count);
    st.full     = count >= MAX_CNT;
    st.p_zero   = p == '0;
    st.sh_move  = rdata.tm > q;
    st.rm_end   = ((CW + 1)'(p) + (CW + 1)'(1)) >= (CW + 1)'(count);
    st.direct   = !bf || !af || (b_pt.tm == q);
    st.cnt_last = cnt == 5'd1;
    st.shape    = b_pt.shape;
  end

  // divider and square root steps
  always_comb begin
    r2        = {rem, 1'b0};
    rsub      = r2 - {1'b0, den};
    ge        = r2 >= {1'b0, den};
    rb        = sres + sbit;
    sge       = sv >= rb;
    sres_next = sge ? (sres >> 1) + sbit : sres >> 1;
  end

  // shared multiplier
  always_comb begin
    diff = $signed({1'b0, a_lvl}) - $signed({1'b0, b_pt.lvl});
    c2s  = $signed({b_pt.c2[15], b_pt.c2}) + 17'sd16384;
    ma   = '0;
    mb   = '0;
    case (op)
      OP_SQR: begin
        ma = $signed({2'b0, t});
        mb = $signed({7'b0, t});
      end
      OP_BZ_UU: begin
        ma = $signed({1'b0, u});
        mb = $signed({6'b0, u});
      end
      OP_BZ_A: begin
        ma = $signed({1'b0, uu});
        mb = $signed({7'b0, t});
      end
      OP_BZ_TT: begin
        ma = $signed({2'b0, t});
        mb = $signed({7'b0, t});
      end
      OP_BZ_B: begin
        ma = $signed({1'b0, u});
        mb = $signed({6'b0, tt});
      end
      OP_BZ_TTT: begin
        ma = $signed({1'b0, tt});
        mb = $signed({7'b0, t});
      end
      OP_BZ_PA: begin
        ma = $signed({1'b0, bza});
        mb = {{7{b_pt.c1[15]}}, b_pt.c1};
      end
      OP_BZ_PB: begin
        ma = $signed({1'b0, bzb});
        mb = $signed({7'b0, c2s[15:0]});
      end
      OP_LERP: begin
        ma = {diff[16], diff};
        mb = c;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    mp = 41'(ma) * 41'(mb);
  end

  always_comb begin
    bz_sum  = acc + $signed({10'b0, ttt, 14'b0}) + 41'sd8192;
    acc_rnd = acc + 41'sd32768;
    lvl_sum = $signed({10'b0, b_pt.lvl}) + {acc_rnd[40], acc_rnd[40:16]};
    if (lvl_sum < 26'sd0) begin
      lvl_sat = 16'd0;
    end else if (lvl_sum > 26'sd65535) begin
      lvl_sat = 16'hFFFF;
    end else begin
      lvl_sat = lvl_sum[15:0];
    end
  end

  // sine table index from the distance to mid-segment
  always_comb begin
    w         = t[15] ? {t, 1'b0} - 17'd65536 : 17'd65536 - {t, 1'b0};
    sprod     = (SW + 18)'(w) * (SW + 18)'(SINE_TABLE_SIZE) + (SW + 18)'(32768);
    sidx_full = sprod[SW+17:16];
    sidx      = (sidx_full > SIN_TOP) ? SIN_TOP[SW-1:0] : sidx_full[SW-1:0];
    sin_hi    = 18'd65536 + {1'b0, s_val};
    sin_lo    = 18'd65536 - {1'b0, s_val};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_level <= '0;
      match_tol     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEFAULT_LEVEL: default_level <= cfg_data;
        CFG_MATCH_TOL:     match_tol     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      rd_vld <= 1'b0;
      ptr    <= '0;
    end else begin
      rd_vld <= 1'b0;
      case (op)
        OP_LOAD: ptr <= '0;
        OP_SCAN: begin
          rd_vld <= ptr < count;
          rd_idx <= ptr[AW-1:0];
          if (ptr < count) begin
            ptr <= ptr + CW'(1);
          end
        end
        OP_CLEAR:   count <= '0;
        OP_WR_NEW:  count <= count + CW'(1);
        OP_RM_DONE: count <= count - CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        q            <= time_stamp;
        new_pt.tm    <= time_stamp;
        new_pt.lvl   <= level_in;
        new_pt.shape <= curve_shape;
        new_pt.c1    <= sat_ctrl(ctrl_one);
        new_pt.c2    <= sat_ctrl(ctrl_two);
        res_status   <= STATUS_OK;
        res_level    <= '0;
        bf           <= 1'b0;
        af           <= 1'b0;
      end
      OP_SCAN: begin
        if (st.hit) begin
          p     <= rd_idx;
          mtime <= rdata.tm;
        end
        if (rd_vld) begin
          if (rdata.tm <= q) begin
            bf   <= 1'b1;
            b_pt <= rdata;
          end else if (!af) begin
            af    <= 1'b1;
            a_tm  <= rdata.tm;
            a_lvl <= rdata.lvl;
          end
        end
      end
      OP_FULL:    res_status <= STATUS_FULL;
      OP_NOMATCH: res_status <= STATUS_NONE;
      OP_SH_INIT: p <= count[AW-1:0];
      OP_SH_CMP: begin
        if (st.sh_move) begin
          p <= p - AW'(1);
        end
      end
      OP_RM_WR:   p <= p + AW'(1);
      OP_QSEL: begin
        if (st.direct) begin
          res_level <= bf ? b_pt.lvl : default_level;
        end
        rem <= q - b_pt.tm;
        den <= a_tm - b_pt.tm;
        t   <= '0;
        cnt <= DIV_STEPS;
      end
      OP_DIV: begin
        rem <= ge ? rsub[31:0] : r2[31:0];
        t   <= {t[14:0], ge};
        cnt <= cnt - 5'd1;
      end
      OP_SHAPE: begin
        c    <= (b_pt.shape == SHAPE_STEPPED) ? 23'sd0 : $signed({7'b0, t});
        u    <= 17'd65536 - {1'b0, t};
        sv   <= {t, 16'b0};
        sres <= '0;
        sbit <= 32'h4000_0000;
        cnt  <= SQRT_STEPS;
      end
      OP_SQRT: begin
        if (sge) begin
          sv <= sv - rb;
        end
        sres <= sres_next;
        sbit <= sbit >> 2;
        cnt  <= cnt - 5'd1;
        c    <= $signed({7'b0, sres_next[15:0]});
      end
      OP_SQR:     c   <= 23'((mp + 41'sd32768) >>> 16);
      OP_BZ_UU:   uu  <= mp[32:16];
      OP_BZ_A:    bza <= mp[32:16];
      OP_BZ_TT:   tt  <= mp[32:16];
      OP_BZ_B:    bzb <= mp[32:16];
      OP_BZ_TTT:  ttt <= mp[32:16];
      OP_BZ_PA:   acc <= mp + (mp <<< 1);
      OP_BZ_PB:   acc <= acc + mp + (mp <<< 1);
      OP_BZ_SUM:  c   <= 23'(bz_sum >>> 14);
      OP_SIN_IDX: s_val <= SINE_ROM[sidx];
      OP_SIN_VAL: c   <= $signed({6'b0, t[15] ? sin_hi[17:1] : sin_lo[17:1]});
      OP_LERP:    acc <= mp;
      OP_FIN:     res_level <= lvl_sat;
      default: ;
    endcase
  end

  assign status      = res_status;
  assign level_out   = res_level;
  assign point_count = 7'(count);

endmodule

`default_nettype wire

### verif/abi_checker.sv
`timescale 1ns / 100ps
// Watches the item, result and register channels of the breakpoint interpolator,
// predicts each result from its own copy of the point table; depends on abi_pkg.
`default_nettype none

module abi_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic               done,
  input  wire logic [1:0]         mode,
  input  wire logic [31:0]        time_stamp,
  input  wire logic [15:0]        level_in,
  input  wire logic [2:0]         curve_shape,
  input  wire logic signed [15:0] ctrl_one,
  input  wire logic signed [15:0] ctrl_two,
  input  wire logic [1:0]         status,
  input  wire logic [15:0]        level_out,
  input  wire logic [6:0]         point_count,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  output int                      errors,
  output int                      pending
);
  import abi_pkg::*;

  localparam int NPTS  = 64;
  localparam int NSINE = 256;

  typedef struct {
    logic [1:0]  st;
    logic [15:0] lvl;
    logic [6:0]  cnt;
  } res_t;

  res_t        awaited_res[$];
  point_t      pts[NPTS];
  int          npts;
  logic [15:0] dflt_lvl;
  logic [15:0] tol;
  longint      quarter_sine[NSINE+1];

  function automatic longint taylor_sine(longint x);
    longint x2, r, s;
    x2 = (x * x) >>> 30;
    r = ONE_Q30;
    r = ONE_Q30 - ((x2 * r) >>> 30) / 110;
    r = ONE_Q30 - ((x2 * r) >>> 30) / 72;
    r = ONE_Q30 - ((x2 * r) >>> 30) / 42;
    r = ONE_Q30 - ((x2 * r) >>> 30) / 20;
    r = ONE_Q30 - ((x2 * r) >>> 30) / 6;
    s = (x * r) >>> 30;
    s = (s + 8192) >>> 14;
    return s > 65536 ? 64'sd65536 : s;
  endfunction

  function automatic longint int_sqrt(longint unsigned v_in);
    longint unsigned v, res, b;
    v = v_in;
    res = 0;
    b = 64'd1 << 30;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  function automatic logic signed [15:0] clamp_ctrl(logic signed [15:0] v);
    if (v > 16384) return 16'sd16384;
    if (v < -16384) return -16'sd16384;
    return v;
  endfunction

  function automatic longint shape_curve(longint t, logic [2:0] shp, longint c1, longint c2);
    longint u, uu, a, tt, b, ttt, sum, d, w, idx, s;
    case (shp)
      SHAPE_SQUARE: return (t * t + 32768) >>> 16;
      SHAPE_SQRT: return int_sqrt(longint'(t) << 16);
      SHAPE_BEZIER: begin
        u = 65536 - t;
        uu = (u * u) >>> 16;
        a = (uu * t) >>> 16;
        tt = (t * t) >>> 16;
        b = (u * tt) >>> 16;
        ttt = (tt * t) >>> 16;
        sum = 3 * a * c1 + 3 * b * (16384 + c2) + (ttt << 14);
        return (sum + 8192) >>> 14;
      end
      SHAPE_SINE: begin
        d = 2 * t - 65536;
        w = d < 0 ? -d : d;
        idx = (w * NSINE + 32768) >>> 16;
        if (idx > NSINE) idx = NSINE;
        s = quarter_sine[idx];
        return (t < 32768) ? ((65536 - s) >>> 1) : ((65536 + s) >>> 1);
      end
      SHAPE_STEPPED: return 0;
      default: return t;
    endcase
  endfunction

  function automatic int find_point(logic [31:0] tm);
    logic [31:0] dif;
    for (int i = 0; i < npts; i++) begin
      dif = pts[i].tm > tm ? pts[i].tm - tm : tm - pts[i].tm;
      if (dif <= {16'd0, tol}) return i;
    end
    return -1;
  endfunction

  function automatic logic [15:0] level_at(logic [31:0] q);
    int bef, aft;
    longint unsigned num, den;
    longint t, c, dif, lv;
    bef = -1;
    aft = -1;
    for (int i = 0; i < npts; i++) begin
      if (pts[i].tm <= q) bef = i;
      else if (aft < 0) aft = i;
    end
    if (bef < 0) return dflt_lvl;
    if (aft < 0 || pts[bef].tm == q) return pts[bef].lvl;
    num = longint'(q - pts[bef].tm) << 16;
    den = longint'(pts[aft].tm - pts[bef].tm);
    t = longint'(num / den);
    c = shape_curve(t, pts[bef].shape, longint'(pts[bef].c1), longint'(pts[bef].c2));
    dif = longint'(pts[aft].lvl) - longint'(pts[bef].lvl);
    lv = longint'(pts[bef].lvl) + ((dif * c + 32768) >>> 16);
    if (lv < 0) lv = 0;
    if (lv > 65535) lv = 65535;
    return lv[15:0];
  endfunction

  function automatic res_t apply_item();
    res_t r;
    int m, p;
    r.st = STATUS_OK;
    r.lvl = 16'd0;
    case (mode)
      MODE_ADD: begin
        m = find_point(time_stamp);
        p = m;
        if (m < 0) begin
          if (npts >= NPTS) begin
            r.st = STATUS_FULL;
          end else begin
            p = npts;
            while (p > 0 && pts[p-1].tm > time_stamp) begin
              pts[p] = pts[p-1];
              p--;
            end
            pts[p].tm = time_stamp;
            npts++;
          end
        end
        if (p >= 0) begin
          pts[p].lvl = level_in;
          pts[p].shape = curve_shape;
          pts[p].c1 = clamp_ctrl(ctrl_one);
          pts[p].c2 = clamp_ctrl(ctrl_two);
        end
      end
      MODE_REMOVE: begin
        m = find_point(time_stamp);
        if (m < 0) begin
          r.st = STATUS_NONE;
        end else begin
          for (int i = m; i + 1 < npts; i++) pts[i] = pts[i+1];
          npts--;
        end
      end
      MODE_QUERY: r.lvl = level_at(time_stamp);
      default: npts = 0;
    endcase
    r.cnt = npts[6:0];
    return r;
  endfunction

  initial begin
    for (int k = 0; k <= NSINE; k++) quarter_sine[k] = taylor_sine(PI_HALF_Q30 * k / NSINE);
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      npts = 0;
      dflt_lvl = 16'd0;
      tol = 16'd0;
      awaited_res.delete();
      pending = 0;
    end else begin
      if (done) begin
        if (awaited_res.size() == 0) begin
          $display("%0t: result with no item outstanding", $time);
          errors++;
        end else begin
          e = awaited_res.pop_front();
          if (status !== e.st) begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, status);
            errors++;
          end
          if (level_out !== e.lvl) begin
            $display("%0t: level_out expected %0d actual %0d", $time, e.lvl, level_out);
            errors++;
          end
          if (point_count !== e.cnt) begin
            $display("%0t: point_count expected %0d actual %0d", $time, e.cnt, point_count);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DEFAULT_LEVEL) dflt_lvl = cfg_data;
        else if (cfg_index == CFG_MATCH_TOL) tol = cfg_data;
      end
      if (start && !busy) begin
        e = apply_item();
        awaited_res = {awaited_res, e};
      end
      pending = awaited_res.size();
    end
  end

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps
// Top of the breakpoint interpolator testbench: clock, reset, item and register
// stimulus and the verdict; depends on abi_pkg, abi_checker and the block itself.
`default_nettype none

module tb;
  import abi_pkg::*;

  localparam int WATCH_LIMIT = 20000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy, done, cfg_ready;
  logic [1:0]         mode = MODE_CLEAR;
  logic [31:0]        time_stamp = '0;
  logic [15:0]        level_in = '0;
  logic [2:0]         curve_shape = '0;
  logic signed [15:0] ctrl_one = '0;
  logic signed [15:0] ctrl_two = '0;
  logic [1:0]         status;
  logic [15:0]        level_out;
  logic [6:0]         point_count;
  logic               cfg_valid = 1'b0;
  logic [1:0]         cfg_index = CFG_DEFAULT_LEVEL;
  logic [15:0]        cfg_data = '0;
  int                 errors, pending;
  int                 idle_pct = 0;
  int                 quiet = 0;

  always #4 clk = ~clk;

  automation_breakpoint_interpolator u_top (
    .clk, .rst, .start, .busy, .done, .mode, .time_stamp, .level_in, .curve_shape,
    .ctrl_one, .ctrl_two, .status, .level_out, .point_count,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  abi_checker u_chk (
    .clk, .rst, .start, .busy, .done, .mode, .time_stamp, .level_in, .curve_shape,
    .ctrl_one, .ctrl_two, .status, .level_out, .point_count,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCH_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] m, logic [31:0] ts, logic [15:0] lv, logic [2:0] sh,
                           logic [15:0] c1, logic [15:0] c2);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start <= 1'b1;
    mode <= m;
    time_stamp <= ts;
    level_in <= lv;
    curve_shape <= sh;
    ctrl_one <= c1;
    ctrl_two <= c2;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rnd_ctrl();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  task automatic random_item(int span);
    int r;
    logic [1:0] m;
    logic [31:0] ts;
    r = $urandom_range(99);
    m = r < 45 ? MODE_ADD : r < 60 ? MODE_REMOVE : r < 98 ? MODE_QUERY : MODE_CLEAR;
    ts = ($urandom_range(9) == 0) ? $urandom : $urandom_range(span);
    send_item(m, ts, 16'($urandom), 3'($urandom), rnd_ctrl(), rnd_ctrl());
  endtask

  task automatic fill_table();
    send_item(MODE_CLEAR, 0, 0, 0, 0, 0);
    for (int i = 0; i < 66; i++)
      send_item(MODE_ADD, i * 1000 + $urandom_range(500), 16'($urandom), 3'($urandom),
                rnd_ctrl(), rnd_ctrl());
    repeat (20) send_item(MODE_QUERY, $urandom_range(70000), 0, 0, 0, 0);
  endtask

  task automatic random_phase(int pct, int n, int span);
    idle_pct = pct;
    for (int i = 0; i < n; i++) random_item(span);
    fill_table();
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(CFG_DEFAULT_LEVEL, 16'hFFFF);
    write_reg(CFG_MATCH_TOL, 16'd0);

    // empty table, then every shape between two points
    send_item(MODE_QUERY, 32'd5, 0, 0, 0, 0);
    send_item(MODE_REMOVE, 32'd5, 0, 0, 0, 0);
    send_item(MODE_ADD, 32'd0, 16'd0, SHAPE_SQUARE, 16'h7FFF, 16'h8000);
    send_item(MODE_ADD, 32'hFFFF_FFFF, 16'hFFFF, 3'd7, 0, 0);
    send_item(MODE_QUERY, 32'h8000_0000, 0, 0, 0, 0);
    send_item(MODE_QUERY, 32'hFFFF_FFFF, 0, 0, 0, 0);
    for (int s = 0; s < 8; s++) begin
      send_item(MODE_ADD, 32'd1000, 16'd60000, 3'(s), 16'sd16384, -16'sd16384);
      send_item(MODE_ADD, 32'd2000, 16'd100, 3'd0, 0, 0);
      send_item(MODE_QUERY, 32'd1000 + $urandom_range(1, 999), 0, 0, 0, 0);
    end
    send_item(MODE_QUERY, 32'd1000, 0, 0, 0, 0);
    send_item(MODE_REMOVE, 32'd1001, 0, 0, 0, 0);
    send_item(MODE_REMOVE, 32'd1000, 0, 0, 0, 0);
    send_item(MODE_CLEAR, 32'd0, 0, 0, 0, 0);
    drain();

    write_reg(CFG_DEFAULT_LEVEL, 16'($urandom));
    write_reg(CFG_MATCH_TOL, 16'd3);
    random_phase(27, 130, 3000);
    write_reg(CFG_DEFAULT_LEVEL, 16'd0);
    write_reg(CFG_MATCH_TOL, 16'hFFFF);
    random_phase(73, 40, 400000);
    write_reg(CFG_DEFAULT_LEVEL, 16'($urandom));
    write_reg(CFG_MATCH_TOL, 16'($urandom_range(50)));
    random_phase(73, 100, 5000);
    write_reg(CFG_MATCH_TOL, 16'd0);
    random_phase(0, 120, 2000);

    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
